FILE: sv/polyline_path_target_follow_top_macros.svh
// Assertion macros for the path target follower.
// Used by polyline_path_target_follow_top; expects aclk and aresetn in scope.
`ifndef POLYLINE_PATH_TARGET_FOLLOW_TOP_MACROS_SVH
`define POLYLINE_PATH_TARGET_FOLLOW_TOP_MACROS_SVH

// same-cycle implication
`define PPF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ppf_pkg.sv
// Shared constants and codes for the path target follower.
// No dependencies.
`default_nettype none

package ppf_pkg;

    localparam int DEF_MAX_POINTS  = 16;
    localparam int DEF_COORD_WIDTH = 24;
    localparam int PIDX_W          = 4;   // point_index / segment_index width
    localparam int NPTS_W          = 5;   // num_points register width
    localparam int SAT_W           = 29;  // coordinates saturate to this signed width

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic {
        REG_NUM_POINTS = 1'b0,
        REG_LOOK_AHEAD = 1'b1
    } cfg_reg_t;

endpackage

`default_nettype wire

FILE: sv/ppf_div.sv
// Iterative signed divider, one quotient bit per cycle, truncates toward zero.
// Divisor is positive. Depends on nothing.
`default_nettype none

module ppf_div #(
    parameter int NUM_W = 61,
    parameter int DEN_W = 30
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic signed [NUM_W-1:0] num,
    input  wire logic        [DEN_W-1:0] den,
    output logic                         busy,
    output logic                         done,
    output logic signed      [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] acc_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W:0]   rem_sub;

    // one restoring step
    always_comb begin
        rem_sh  = {rem_reg, acc_reg[NUM_W-1]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
        end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= num[NUM_W-1] ? NUM_W'(-num) : num;
            neg_reg <= num[NUM_W-1];
            rem_reg <= '0;
            den_reg <= den;
            cnt_reg <= CNT_W'(NUM_W);
        end else if (busy_reg) begin
            acc_reg <= {acc_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = neg_reg ? NUM_W'(-acc_reg) : acc_reg;

endmodule

`default_nettype wire

FILE: sv/ppf_sqrt.sv
// Iterative integer square root (floor), one result bit per cycle.
// Depends on nothing.
`default_nettype none

module ppf_sqrt #(
    parameter int SQ_W = 60
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [SQ_W-1:0]       val,
    output logic                       busy,
    output logic                       done,
    output logic [SQ_W/2-1:0]          root
);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [SQ_W-1:0] n_reg, r_reg, b_reg;
    logic [SQ_W-1:0] t;
    logic            ge;

    always_comb begin
        t  = r_reg + b_reg;
        ge = n_reg >= t;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
        end else if (busy_reg && b_reg == SQ_W'(1)) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // digit-by-digit root
    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg <= val;
            r_reg <= '0;
            b_reg <= SQ_W'(1) << (SQ_W - 2);
        end else if (busy_reg) begin
            if (ge) begin
                n_reg <= n_reg - t;
                r_reg <= (r_reg >> 1) + b_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            b_reg <= b_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = r_reg[SQ_W/2-1:0];

endmodule

`default_nettype wire

FILE: sv/polyline_path_target_follow_top.sv
// Path target follower: a query walks the polyline segments one at a time.
// Each segment pass takes the root and up to three serial divisions on the shared units; a
// query runs nseg passes plus at most one final pass, then waits for the output register to
// be free. A load is written on acceptance. One request in flight at a time. Reset: synchronous
// active-low; clears control state, sets num_points 2 and ahead distance 0. Path memory is not
// cleared; unloaded points are garbage.
`default_nettype none
`include "polyline_path_target_follow_top_macros.svh"

module polyline_path_target_follow_top
    import ppf_pkg::*;
#(
    parameter int MAX_POINTS  = DEF_MAX_POINTS,
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // config write port
    input  wire logic                       cfg_wr_en,
    input  wire logic                       cfg_addr,
    input  wire logic [COORD_WIDTH-1:0]     cfg_wdata,
    // request in
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // tdata: point_index, pos_x, pos_y (low bit up), zero pad
    input  wire logic [((PIDX_W+2*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // tuser: op
    input  wire logic                       s_tuser,
    // result out
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // tdata: target_x, target_y, segment_index (low bit up), zero pad
    output logic [((PIDX_W+2*COORD_WIDTH+7)/8)*8-1:0] m_tdata
);

    localparam int TD_W = ((PIDX_W + 2*COORD_WIDTH + 7) / 8) * 8;
    localparam int IW   = (COORD_WIDTH > SAT_W) ? SAT_W : COORD_WIDTH;
    localparam int DW   = IW + 1;          // coordinate differences
    localparam int MW   = DW + 1;          // multiplier operands
    localparam int PRW  = 2 * MW;          // product
    localparam int SQW  = 2 * DW;          // squared lengths
    localparam int PW   = 2 * DW + 1;      // dot products, dividends
    localparam int AW   = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int XW   = ((AW > NPTS_W) ? AW : NPTS_W) + 1;
    localparam int SXW  = (AW > PIDX_W) ? AW : PIDX_W;

    typedef enum logic [22:0] {
        S_IDLE = 23'h000001, S_RDA  = 23'h000002, S_RDB  = 23'h000004,
        S_DIFF = 23'h000008, S_M0   = 23'h000010, S_M1   = 23'h000020,
        S_M2   = 23'h000040, S_M3   = 23'h000080, S_M4   = 23'h000100,
        S_SQRT = 23'h000200, S_DIVP = 23'h000400, S_PROJ = 23'h000800,
        S_M5   = 23'h001000, S_M6   = 23'h002000, S_M7   = 23'h004000,
        S_DIVX = 23'h008000, S_DIVY = 23'h010000, S_ERR  = 23'h020000,
        S_E0   = 23'h040000, S_E1   = 23'h080000, S_E2   = 23'h100000,
        S_NEXT = 23'h200000, S_OUT  = 23'h400000
    } state_t;

    function automatic logic signed [IW-1:0] sat(input logic [COORD_WIDTH-1:0] v);
        logic [COORD_WIDTH-IW:0] hi;
        hi = v[COORD_WIDTH-1:IW-1];
        if (hi == '0 || hi == '1) begin
            return v[IW-1:0];
        end else if (v[COORD_WIDTH-1]) begin
            return {1'b1, {(IW-1){1'b0}}};
        end else begin
            return {1'b0, {(IW-1){1'b1}}};
        end
    endfunction

    state_t state_reg, state_next;

    // config registers
    logic [NPTS_W-1:0]     npts_reg;
    logic signed [IW-1:0]  la_reg;

    // path memory {y, x}
    logic [2*IW-1:0] path_mem [MAX_POINTS];
    logic [2*IW-1:0] mem_q_reg;
    logic [AW-1:0]   rd_addr;

    // query registers
    logic signed [IW-1:0]  px_reg, py_reg, ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [IW-1:0]  tx_reg, ty_reg, best_tx_reg, best_ty_reg;
    logic signed [DW-1:0]  dx_reg, dy_reg, vx_reg, vy_reg, ex_reg, ey_reg;
    logic signed [PRW-1:0] prod_reg;
    logic [SQW-1:0]        sq_reg, d_reg, best_d_reg;
    logic signed [PW-1:0]  dot_reg, numy_reg;
    logic [DW-1:0]         len_reg;
    logic signed [PW:0]    proj_reg;
    logic [AW-1:0]         seg_reg, nseg_reg, best_reg;
    logic                  passed_reg, best_pass_reg, first_reg, final_reg;
    logic                  m_tvalid_reg;
    logic [TD_W-1:0]       m_tdata_reg;

    // shared units
    logic                  div_start, div_busy, div_done;
    logic signed [PW-1:0]  div_num, div_quo;
    logic                  sqrt_start, sqrt_busy, sqrt_done;
    logic [DW-1:0]         sqrt_root;

    logic signed [MW-1:0]  mul_a, mul_b;
    logic                  in_acc, out_load;
    logic [PIDX_W-1:0]     in_idx;
    logic [XW-1:0]         idx_ext, n_ext;
    logic [SQW-1:0]        d_sum;
    logic signed [PW:0]    len_ext;
    logic [AW-1:0]         last_seg;
    logic [SXW-1:0]        best_w;
    logic signed [COORD_WIDTH-1:0] tx_o, ty_o;

    assign in_acc   = s_tvalid && s_tready;
    assign in_idx   = s_tdata[PIDX_W-1:0];
    assign idx_ext  = XW'(in_idx);
    assign last_seg = nseg_reg - AW'(1);
    assign len_ext  = (PW+1)'({1'b0, len_reg});
    assign d_sum    = d_reg + SQW'(prod_reg);

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            npts_reg <= NPTS_W'(2);
            la_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_NUM_POINTS: npts_reg <= cfg_wdata[NPTS_W-1:0];
                REG_LOOK_AHEAD: la_reg   <= sat(cfg_wdata);
                default: ;
            endcase
        end
    end

    // path memory: write on load, registered read
    always_comb begin
        rd_addr = seg_reg;
        if (state_reg == S_RDB) begin
            rd_addr = seg_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && s_tuser == OP_LOAD && idx_ext < XW'(MAX_POINTS)) begin
            path_mem[idx_ext[AW-1:0]] <= {sat(s_tdata[PIDX_W+COORD_WIDTH +: COORD_WIDTH]),
                                          sat(s_tdata[PIDX_W +: COORD_WIDTH])};
        end
        mem_q_reg <= path_mem[rd_addr];
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = MW'(dx_reg);
        mul_b = MW'(dx_reg);
        case (state_reg)
            S_M1:    begin mul_a = MW'(dy_reg); mul_b = MW'(dy_reg); end
            S_M2:    begin mul_a = MW'(vx_reg); mul_b = MW'(dx_reg); end
            S_M3:    begin mul_a = MW'(vy_reg); mul_b = MW'(dy_reg); end
            S_M5:    begin mul_a = MW'(dx_reg); mul_b = {1'b0, proj_reg[DW-1:0]}; end
            S_M6:    begin mul_a = MW'(dy_reg); mul_b = {1'b0, proj_reg[DW-1:0]}; end
            S_E0:    begin mul_a = MW'(ex_reg); mul_b = MW'(ex_reg); end
            S_E1:    begin mul_a = MW'(ey_reg); mul_b = MW'(ey_reg); end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // unit starts
    always_comb begin
        div_start  = 1'b0;
        div_num    = dot_reg;
        sqrt_start = (state_reg == S_M3);
        case (state_reg)
            S_SQRT: div_start = sqrt_done && sqrt_root != '0;
            S_M6: begin
                div_start = 1'b1;
                div_num   = prod_reg[PW-1:0];
            end
            S_DIVX: begin
                div_start = div_done;
                div_num   = numy_reg;
            end
            default: ;
        endcase
    end

    ppf_div #(.NUM_W(PW), .DEN_W(DW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (state_reg == S_SQRT ? sqrt_root : len_reg),
        .busy    (div_busy),
        .done    (div_done),
        .quo     (div_quo)
    );

    ppf_sqrt #(.SQ_W(SQW)) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .val     (sq_reg),
        .busy    (sqrt_busy),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE: if (in_acc && s_tuser == OP_QUERY) state_next = S_RDA;
            S_RDA:  state_next = S_RDB;
            S_RDB:  state_next = S_DIFF;
            S_DIFF: state_next = S_M0;
            S_M0:   state_next = S_M1;
            S_M1:   state_next = S_M2;
            S_M2:   state_next = S_M3;
            S_M3:   state_next = S_M4;
            S_M4:   state_next = S_SQRT;
            S_SQRT: begin
                if (sqrt_done) begin
                    state_next = (sqrt_root == '0) ? S_PROJ : S_DIVP;
                end
            end
            S_DIVP: if (div_done) state_next = S_PROJ;
            S_PROJ: begin
                if (proj_reg > len_ext || proj_reg < 0 || len_reg == '0) begin
                    state_next = final_reg ? S_OUT : S_ERR;
                end else begin
                    state_next = S_M5;
                end
            end
            S_M5:   state_next = S_M6;
            S_M6:   state_next = S_M7;
            S_M7:   state_next = S_DIVX;
            S_DIVX: if (div_done) state_next = S_DIVY;
            S_DIVY: if (div_done) state_next = final_reg ? S_OUT : S_ERR;
            S_ERR:  state_next = S_E0;
            S_E0:   state_next = S_E1;
            S_E1:   state_next = S_E2;
            S_E2:   state_next = S_NEXT;
            S_NEXT: begin
                if (seg_reg == last_seg && !(best_pass_reg && best_reg != last_seg)) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_RDA;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // point count clamp
    always_comb begin
        n_ext = XW'(npts_reg);
        if (n_ext < XW'(2)) begin
            n_ext = XW'(2);
        end else if (n_ext > XW'(MAX_POINTS)) begin
            n_ext = XW'(MAX_POINTS);
        end
    end

    // query datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                px_reg    <= sat(s_tdata[PIDX_W +: COORD_WIDTH]);
                py_reg    <= sat(s_tdata[PIDX_W+COORD_WIDTH +: COORD_WIDTH]);
                nseg_reg  <= AW'(n_ext - XW'(1));
                seg_reg   <= '0;
                final_reg <= 1'b0;
                first_reg <= 1'b1;
            end
            S_RDB: begin
                ax_reg <= mem_q_reg[IW-1:0];
                ay_reg <= mem_q_reg[2*IW-1:IW];
            end
            S_DIFF: begin
                bx_reg <= mem_q_reg[IW-1:0];
                by_reg <= mem_q_reg[2*IW-1:IW];
                dx_reg <= DW'(signed'(mem_q_reg[IW-1:0])) - DW'(ax_reg);
                dy_reg <= DW'(signed'(mem_q_reg[2*IW-1:IW])) - DW'(ay_reg);
                vx_reg <= DW'(px_reg) - DW'(ax_reg);
                vy_reg <= DW'(py_reg) - DW'(ay_reg);
            end
            S_M1: sq_reg <= SQW'(prod_reg);
            S_M2: sq_reg <= sq_reg + SQW'(prod_reg);
            S_M3: dot_reg <= PW'(prod_reg);
            S_M4: dot_reg <= dot_reg + PW'(prod_reg);
            S_SQRT: begin
                len_reg  <= sqrt_root;
                proj_reg <= (PW+1)'(la_reg);
            end
            S_DIVP: proj_reg <= (PW+1)'(la_reg) + (PW+1)'(div_quo);
            S_PROJ: begin
                passed_reg <= proj_reg > len_ext;
                if (proj_reg > len_ext) begin
                    tx_reg <= bx_reg;
                    ty_reg <= by_reg;
                end else begin
                    tx_reg <= ax_reg;
                    ty_reg <= ay_reg;
                end
            end
            S_M7: numy_reg <= PW'(prod_reg);
            S_DIVX: tx_reg <= ax_reg + IW'(div_quo);
            S_DIVY: ty_reg <= ay_reg + IW'(div_quo);
            S_ERR: begin
                ex_reg <= DW'(px_reg) - DW'(tx_reg);
                ey_reg <= DW'(py_reg) - DW'(ty_reg);
            end
            S_E1: d_reg <= SQW'(prod_reg);
            S_E2: begin
                // nearest so far; later segment wins a tie
                if (first_reg || d_sum <= best_d_reg) begin
                    best_d_reg    <= d_sum;
                    best_reg      <= seg_reg;
                    best_tx_reg   <= tx_reg;
                    best_ty_reg   <= ty_reg;
                    best_pass_reg <= passed_reg;
                end
                first_reg <= 1'b0;
            end
            S_NEXT: begin
                if (seg_reg != last_seg) begin
                    seg_reg <= seg_reg + AW'(1);
                end else if (best_pass_reg && best_reg != last_seg) begin
                    // step on to the following segment
                    seg_reg   <= best_reg + AW'(1);
                    final_reg <= 1'b1;
                end else begin
                    tx_reg <= best_tx_reg;
                    ty_reg <= best_ty_reg;
                end
            end
            default: ;
        endcase
    end

    // output register
    assign tx_o   = COORD_WIDTH'(tx_reg);
    assign ty_o   = COORD_WIDTH'(ty_reg);
    assign best_w = SXW'(best_reg);

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= TD_W'({best_w[PIDX_W-1:0], ty_o, tx_o});
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `PPF_ASSERT_IMP(a_div_start_free, div_start, !div_busy, "divider started while busy")
    `PPF_ASSERT_IMP(a_sqrt_start_free, sqrt_start, !sqrt_busy, "root unit started while busy")
    `PPF_ASSERT_IMP(a_best_in_range, out_load, best_reg < nseg_reg, "segment index past the path")
    `PPF_ASSERT_NXT(a_query_starts, in_acc && s_tuser == OP_QUERY, state_reg == S_RDA,
        "query request did not start a walk")

endmodule

`default_nettype wire

FILE: tb/sv/polyline_path_target_follow_top_tb.sv
// Testbench for the polyline path target follower: loads path points, queries
// targets, and checks every result against a built-in predictor or a table value.
// Depends on ppf_pkg and polyline_path_target_follow_top.
`default_nettype none

module polyline_path_target_follow_top_tb;
    import ppf_pkg::*;

    localparam int CW  = DEF_COORD_WIDTH;
    localparam int NP  = DEF_MAX_POINTS;
    localparam int DW  = ((PIDX_W + 2*CW + 7)/8)*8;
    // worst query: 16 passes of the serial segment datapath
    localparam int QUERY_CYC = 16 * (7*(CW+1) + 22);

    typedef struct packed {
        logic [CW-1:0]     ty;
        logic [CW-1:0]     tx;
        logic [PIDX_W-1:0] seg;
    } target_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_addr = 1'b0;
    logic [CW-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [DW-1:0] m_tdata;

    polyline_path_target_follow_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    longint path_x[NP];
    longint path_y[NP];
    bit     loaded[NP];
    int     pts_used;
    longint ahead;

    target_t pending_targets[$];
    int      errors = 0;
    int      src_idle = 0;   // percent
    int      snk_stall = 0;  // percent

    function automatic longint sx(logic [CW-1:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint int_sqrt(longint n);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    // look-ahead point on segment s; returns 1 when the projection runs past its end
    function automatic bit lookahead_point(int s, longint qx, longint qy,
                                           output longint tx, output longint ty);
        longint ax, ay, bx, by, dx, dy, len, proj;
        ax = path_x[s % NP];  ay = path_y[s % NP];
        bx = path_x[(s+1) % NP];  by = path_y[(s+1) % NP];
        dx = bx - ax;  dy = by - ay;
        len = int_sqrt(dx*dx + dy*dy);
        proj = ahead;
        if (len > 0) proj += ((qx-ax)*dx + (qy-ay)*dy) / len;
        if (proj > len) begin
            tx = bx;  ty = by;
            return 1'b1;
        end
        if (proj < 0 || len == 0) begin
            tx = ax;  ty = ay;
        end else begin
            tx = ax + dx*proj/len;
            ty = ay + dy*proj/len;
        end
        return 1'b0;
    endfunction

    function automatic target_t follow_target(longint qx, longint qy);
        target_t r;
        int n, nseg, best;
        longint tx, ty, ex, ey, d2, best_d;
        bit past;
        n = pts_used < 2 ? 2 : (pts_used > NP ? NP : pts_used);
        nseg = n - 1;
        best = 0;
        best_d = -1;
        for (int s = 0; s < nseg; s++) begin
            void'(lookahead_point(s, qx, qy, tx, ty));
            ex = qx - tx;  ey = qy - ty;
            d2 = ex*ex + ey*ey;
            if (best_d < 0 || d2 <= best_d) begin
                best_d = d2;
                best = s;
            end
        end
        past = lookahead_point(best, qx, qy, tx, ty);
        if (past && best != nseg - 1) void'(lookahead_point(best+1, qx, qy, tx, ty));
        r.tx = tx[CW-1:0];
        r.ty = ty[CW-1:0];
        r.seg = best[PIDX_W-1:0];
        return r;
    endfunction

    // send one request; wait for its acceptance and update the predictor
    // tvalid stays high after acceptance until the next request or an idle cycle
    task automatic send_request(op_t op, logic [PIDX_W-1:0] idx,
                                logic [CW-1:0] x, logic [CW-1:0] y,
                                bit has_exp = 0, target_t exp_t = '0);
        target_t t;
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(DW-PIDX_W-2*CW){1'b0}}, y, x, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == OP_LOAD) begin
            path_x[idx] = sx(x);
            path_y[idx] = sx(y);
            loaded[idx] = 1'b1;
        end else begin
            t = follow_target(sx(x), sx(y));
            if (has_exp && t != exp_t) begin
                $display("%0t predictor disagrees with table: expected %h, got %h",
                         $time, exp_t, t);
                errors++;
            end
            pending_targets.insert(pending_targets.size(), has_exp ? exp_t : t);
        end
    endtask

    task automatic write_reg(cfg_reg_t r, logic [CW-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (r == REG_NUM_POINTS) pts_used = int'(v[NPTS_W-1:0]);
        else ahead = sx(v);
        @(posedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_targets.size() != 0) @(posedge aclk);
        repeat (QUERY_CYC + 20) @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        target_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.tx  = m_tdata[CW-1:0];
            got.ty  = m_tdata[2*CW-1:CW];
            got.seg = m_tdata[2*CW+PIDX_W-1:2*CW];
            if (pending_targets.size() == 0) begin
                $display("%0t unexpected result: expected none, got %h", $time, got);
                errors++;
            end else begin
                want = pending_targets.pop_front();
                if (got.tx !== want.tx || got.ty !== want.ty || got.seg !== want.seg) begin
                    $display("%0t mismatch: expected x=%h y=%h seg=%0d, got x=%h y=%h seg=%0d",
                             $time, want.tx, want.ty, want.seg, got.tx, got.ty, got.seg);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= snk_stall);

    function automatic logic [CW-1:0] rand_coord(int mode);
        case (mode)
            0: return CW'($urandom);
            1: return CW'($signed($urandom_range(8192)) - 4096);
            default: return CW'($signed($urandom_range(400000)) - 200000);
        endcase
    endfunction

    // directed rows: op, index, x, y, has expected, expected
    typedef struct {
        op_t op; logic [3:0] idx; logic [CW-1:0] x; logic [CW-1:0] y;
        bit chk; target_t t;
    } row_t;

    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    initial begin
        row_t rows[$];
        int n_items, npts;
        for (int i = 0; i < NP; i++) begin
            path_x[i] = 0; path_y[i] = 0; loaded[i] = 0;
        end
        pts_used = 2;
        ahead = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, zero-length segment, past-the-end
        rows = '{
            '{OP_LOAD,  4'd0, CW'(0),    CW'(0),    0, '0},
            '{OP_LOAD,  4'd1, CW'(2560), CW'(0),    0, '0},
            '{OP_QUERY, 4'd9, CW'(1280), CW'(256),  1, '{ty: CW'(0), tx: CW'(1280), seg: 4'd0}},
            '{OP_QUERY, 4'd0, CW'(-512), CW'(0),    1, '{ty: CW'(0), tx: CW'(0), seg: 4'd0}},
            '{OP_QUERY, 4'd0, CW'(9000), CW'(0),    1, '{ty: CW'(0), tx: CW'(2560), seg: 4'd0}},
            '{OP_QUERY, 4'hf, CMAX,      CMAX,      0, '0},
            '{OP_QUERY, 4'h0, CMIN,      CMIN,      0, '0},
            '{OP_LOAD,  4'd1, CMAX,      CMIN,      0, '0},
            '{OP_QUERY, 4'd0, CMIN,      CMAX,      0, '0},
            '{OP_LOAD,  4'd1, CW'(0),    CW'(0),    0, '0},
            '{OP_QUERY, 4'd0, CW'(77),   CW'(-33),  1, '{ty: CW'(0), tx: CW'(0), seg: 4'd0}},
            '{OP_LOAD,  4'd1, CW'(0),    CW'(2560), 0, '0},
            '{OP_LOAD,  4'd2, CW'(2560), CW'(2560), 0, '0}
        };
        foreach (rows[i])
            send_request(rows[i].op, rows[i].idx, rows[i].x, rows[i].y,
                         rows[i].chk, rows[i].t);
        drain();
        write_reg(REG_NUM_POINTS, CW'(3));
        write_reg(REG_LOOK_AHEAD, CW'(512));
        send_request(OP_QUERY, 4'd0, CW'(100), CW'(2400));
        send_request(OP_QUERY, 4'd0, CW'(2560), CW'(2560));
        for (int i = 3; i < NP; i++)
            send_request(OP_LOAD, PIDX_W'(i), rand_coord(1), rand_coord(1));
        drain();

        // random phases across idling patterns and register settings
        n_items = 0;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin src_idle = 0;  snk_stall = 0;  end
                1: begin src_idle = 87; snk_stall = 0;  end
                2: begin src_idle = 0;  snk_stall = 87; end
                default: begin src_idle = 34; snk_stall = 34; end
            endcase
            drain();
            case (ph)
                0: npts = 2;
                1: npts = 16;
                2: npts = 0;
                3: npts = 31;
                default: npts = $urandom_range(2, 16);
            endcase
            write_reg(REG_NUM_POINTS, CW'(npts));
            case (ph)
                0: write_reg(REG_LOOK_AHEAD, CMAX);
                1: write_reg(REG_LOOK_AHEAD, CMIN);
                2: write_reg(REG_LOOK_AHEAD, CW'(0));
                default: write_reg(REG_LOOK_AHEAD, rand_coord(1 + ($urandom & 1)));
            endcase
            for (int k = 0; k < 235; k++) begin
                int m;
                m = $urandom_range(2);
                if ($urandom_range(3) == 0)
                    send_request(OP_LOAD, PIDX_W'($urandom), rand_coord(m), rand_coord(m));
                else
                    send_request(OP_QUERY, PIDX_W'($urandom), rand_coord(m), rand_coord(m));
                n_items++;
            end
        end
        drain();

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial begin
        #400000000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
